### sv/assert_macros.svh
// Assertion macros used by the shortest-path top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every sampled edge outside reset.
`define SSSP_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sssp_pkg.sv
// Shared types and constants of the shortest-path block.
`timescale 1ns / 1ps
`default_nettype none

package sssp_pkg;

    localparam int NODE_W   = 6;
    localparam int NODES    = 64;
    localparam int CNT_W    = 7;
    localparam int DIST_W   = 40;
    localparam int WEIGHT_W = 32;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  NODE_LIMIT       = 7'd64;
    localparam logic [DIST_W-1:0] DIST_MAX         = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_NODE = 1'd0,
        CFG_NODE_COUNT  = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [NODE_W-1:0]   tail;
        logic [NODE_W-1:0]   head;
        logic [WEIGHT_W-1:0] len;
    } t_edge;

endpackage

`default_nettype wire

### sv/sssp_req_if.sv
// Request channel: edge load, run and clear beats.
`timescale 1ns / 1ps
`default_nettype none

interface sssp_req_if;
    logic                            valid;
    logic                            ready;
    logic [sssp_pkg::REQ_W-1:0]      req_type;
    logic [sssp_pkg::NODE_W-1:0]     edge_from;
    logic [sssp_pkg::NODE_W-1:0]     edge_to;
    logic [sssp_pkg::WEIGHT_W-1:0]   edge_weight;

    modport source (output valid, req_type, edge_from, edge_to, edge_weight, input ready);
    modport sink   (input valid, req_type, edge_from, edge_to, edge_weight, output ready);
endinterface

`default_nettype wire

### sv/sssp_res_if.sv
// Result channel: one beat per node of a run.
`timescale 1ns / 1ps
`default_nettype none

interface sssp_res_if;
    logic                          valid;
    logic                          ready;
    logic [sssp_pkg::NODE_W-1:0]   node_index;
    logic [sssp_pkg::DIST_W-1:0]   distance;
    logic                          reached;
    logic [sssp_pkg::NODE_W-1:0]   parent_index;
    logic                          has_parent;
    logic                          edges_dropped;
    logic                          last;

    modport source (output valid, node_index, distance, reached, parent_index, has_parent,
                    edges_dropped, last, input ready);
    modport sink   (input valid, node_index, distance, reached, parent_index, has_parent,
                    edges_dropped, last, output ready);
endinterface

`default_nettype wire

### sv/single_source_shortest_paths_top.sv
// Shortest-path engine: edge table, settle/relax sequencer and result emitter.
//
// Usage:
//   i_req carries requests: add edge, run, clear edge table. Add and clear
//   leave the engine idle, so edges load back to back at one beat per cycle.
//   Edges beyond MAX_EDGES are dropped and flag edges_dropped until a clear.
//   A run takes the source and node count from the config port (write only
//   while idle), then repeats rounds: a scan over the n nodes in use finds
//   the queued node of least distance, ST_PICK takes it off the queue, then its
//   relaxation walks the whole edge table, reading and checking each edge, with
//   an update step for each edge from that node into a node in use.
//   All of it uses one distance write port and read port and one edge read port.
//   Rounds run until no node is queued (at most n); then n results leave on
//   o_res in node order, each read before it is loaded; last set on the final one.
//   i_req.ready stays low for the whole run.
//   A stalled receiver holds the output register and pauses the emitter;
//   after the final beat is loaded new requests are taken again.
//   Reset (synchronous, active low) empties the edge table, clears the drop
//   flag and sets source 0, node count 64. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module single_source_shortest_paths_top #(
    parameter int MAX_EDGES = 256
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [sssp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [sssp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    sssp_req_if.sink                             i_req,
    sssp_res_if.source                           o_res
);

    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NODES  = sssp_pkg::NODES;
    localparam int NODE_W = sssp_pkg::NODE_W;
    localparam int CNT_W  = sssp_pkg::CNT_W;
    localparam int DIST_W = sssp_pkg::DIST_W;
    localparam int WEIGHT_W = sssp_pkg::WEIGHT_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SCAN     = 9'b000000010,
        ST_PICK     = 9'b000000100,
        ST_EDGE_RD  = 9'b000001000,
        ST_EDGE_CHK = 9'b000010000,
        ST_EDGE_UPD = 9'b000100000,
        ST_EMIT_RD  = 9'b001000000,
        ST_EMIT_OUT = 9'b010000000,
        ST_UNUSED   = 9'b100000000
    } t_state;

    t_state                  r_state;
    logic [NODE_W-1:0]       r_src;
    logic [CNT_W-1:0]        r_ncount;
    logic [ECNT_W-1:0]       r_etotal;
    logic                    r_overflow;
    logic [NODES-1:0]        r_reached;
    logic [NODES-1:0]        r_queued;
    logic [NODES-1:0]        r_pvalid;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_round;
    logic [ECNT_W-1:0]       r_eidx;
    logic                    r_rd_vld;
    logic [NODE_W-1:0]       r_rd_idx;
    logic                    r_found;
    logic [NODE_W-1:0]       r_best;
    logic [DIST_W-1:0]       r_best_dist;

    // output register
    logic                    r_o_valid;
    logic [NODE_W-1:0]       r_o_node;
    logic [DIST_W-1:0]       r_o_dist;
    logic                    r_o_reached;
    logic [NODE_W-1:0]       r_o_parent;
    logic                    r_o_has_parent;
    logic                    r_o_dropped;
    logic                    r_o_last;

    // memories
    sssp_pkg::t_edge         edge_mem [MAX_EDGES];
    logic [DIST_W-1:0]       dist_mem [NODES];
    logic [NODE_W-1:0]       par_mem  [NODES];
    sssp_pkg::t_edge         r_edge_rd;
    logic [DIST_W-1:0]       r_dist_rd;
    logic [NODE_W-1:0]       r_par_rd;

    logic                    req_acc;
    logic                    run_acc;
    logic                    edge_we;
    logic                    table_full;
    logic [CNT_W-1:0]        node_lim;
    logic                    src_in;
    logic                    edge_hit;
    logic [DIST_W:0]         relax_sum;
    logic [DIST_W-1:0]       relax_t;
    logic                    relax_take;
    logic                    dist_we;
    logic [NODE_W-1:0]       dist_waddr;
    logic [DIST_W-1:0]       dist_wdata;
    logic [NODE_W-1:0]       dist_raddr;
    logic                    emit_free;
    logic                    emit_reached;
    logic                    emit_parent;

    assign req_acc    = i_req.valid && i_req.ready;
    assign run_acc    = req_acc && (i_req.req_type == sssp_pkg::REQ_RUN);
    assign table_full = (r_etotal >= ECNT_W'(MAX_EDGES));
    assign edge_we    = req_acc && (i_req.req_type == sssp_pkg::REQ_ADD) && !table_full;
    assign node_lim   = (r_ncount > sssp_pkg::NODE_LIMIT) ? sssp_pkg::NODE_LIMIT : r_ncount;
    assign src_in     = ({1'b0, r_src} < node_lim);

    assign edge_hit   = (r_edge_rd.tail == r_best) && ({1'b0, r_edge_rd.head} < node_lim);

    // saturating add: key plus edge length, clamped at the field maximum
    assign relax_sum  = {1'b0, r_best_dist} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, r_edge_rd.len};
    assign relax_t    = relax_sum[DIST_W] ? sssp_pkg::DIST_MAX : relax_sum[DIST_W-1:0];
    assign relax_take = !r_reached[r_edge_rd.head] || (relax_t < r_dist_rd);

    assign dist_we    = (r_state == ST_IDLE && run_acc && src_in)
                     || (r_state == ST_EDGE_UPD && relax_take);
    assign dist_waddr = (r_state == ST_EDGE_UPD) ? r_edge_rd.head : r_src;
    assign dist_wdata = (r_state == ST_EDGE_UPD) ? relax_t : '0;
    assign dist_raddr = (r_state == ST_EDGE_CHK) ? r_edge_rd.head : r_idx[NODE_W-1:0];

    assign emit_free    = !r_o_valid || o_res.ready;
    assign emit_reached = r_reached[r_idx[NODE_W-1:0]];
    assign emit_parent  = emit_reached && r_pvalid[r_idx[NODE_W-1:0]];

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_res.valid         = r_o_valid;
    assign o_res.node_index    = r_o_node;
    assign o_res.distance      = r_o_dist;
    assign o_res.reached       = r_o_reached;
    assign o_res.parent_index  = r_o_parent;
    assign o_res.has_parent    = r_o_has_parent;
    assign o_res.edges_dropped = r_o_dropped;
    assign o_res.last          = r_o_last;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[r_etotal[EIDX_W-1:0]] <= '{tail: i_req.edge_from,
                                                head: i_req.edge_to,
                                                len:  i_req.edge_weight};
        end
        if (r_state == ST_EDGE_RD && r_eidx != r_etotal) begin
            r_edge_rd <= edge_mem[r_eidx[EIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        r_dist_rd <= dist_mem[dist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EDGE_UPD && relax_take) begin
            par_mem[r_edge_rd.head] <= r_best;
        end
        r_par_rd <= par_mem[r_idx[NODE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_src      <= '0;
            r_ncount   <= sssp_pkg::NODE_COUNT_RESET;
            r_etotal   <= '0;
            r_overflow <= 1'b0;
            r_reached  <= '0;
            r_queued   <= '0;
            r_pvalid   <= '0;
            r_idx      <= '0;
            r_round    <= '0;
            r_eidx     <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sssp_pkg::CFG_SOURCE_NODE: r_src    <= i_cfg_wdata[NODE_W-1:0];
                    sssp_pkg::CFG_NODE_COUNT:  r_ncount <= i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // in ST_EMIT_OUT a taken beat is replaced by the emitter below
            if (o_res.valid && o_res.ready && r_state != ST_EMIT_OUT) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (req_acc) begin
                        case (i_req.req_type)
                            sssp_pkg::REQ_ADD: begin
                                if (!table_full) begin
                                    r_etotal <= r_etotal + 1'b1;
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            sssp_pkg::REQ_CLEAR: begin
                                r_etotal   <= '0;
                                r_overflow <= 1'b0;
                            end
                            sssp_pkg::REQ_RUN: begin
                                r_idx    <= '0;
                                r_pvalid <= '0;
                                r_found  <= 1'b0;
                                r_rd_vld <= 1'b0;
                                r_round  <= '0;
                                if (src_in) begin
                                    r_reached <= NODES'(1) << r_src;
                                    r_queued  <= NODES'(1) << r_src;
                                    r_state   <= ST_SCAN;
                                end else begin
                                    r_reached <= '0;
                                    r_queued  <= '0;
                                    r_state   <= (node_lim == '0) ? ST_IDLE : ST_EMIT_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // read pipeline over the nodes in use; compare in the cycle after the read
                ST_SCAN: begin
                    if (r_idx < node_lim) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[NODE_W-1:0];
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld && r_queued[r_rd_idx]
                        && (!r_found || r_dist_rd < r_best_dist)) begin
                        r_found     <= 1'b1;
                        r_best      <= r_rd_idx;
                        r_best_dist <= r_dist_rd;
                    end
                    if (r_idx == node_lim && !r_rd_vld) begin
                        r_state <= ST_PICK;
                    end
                end

                ST_PICK: begin
                    if (!r_found || r_round == node_lim) begin
                        r_idx   <= '0;
                        r_state <= ST_EMIT_RD;
                    end else begin
                        r_queued[r_best] <= 1'b0;
                        r_round          <= r_round + 1'b1;
                        r_eidx           <= '0;
                        r_state          <= ST_EDGE_RD;
                    end
                end

                ST_EDGE_RD: begin
                    if (r_eidx == r_etotal) begin
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_rd_vld <= 1'b0;
                        r_state  <= ST_SCAN;
                    end else begin
                        r_state <= ST_EDGE_CHK;
                    end
                end

                ST_EDGE_CHK: begin
                    if (edge_hit) begin
                        r_state <= ST_EDGE_UPD;
                    end else begin
                        r_eidx  <= r_eidx + 1'b1;
                        r_state <= ST_EDGE_RD;
                    end
                end

                ST_EDGE_UPD: begin
                    if (relax_take) begin
                        r_reached[r_edge_rd.head] <= 1'b1;
                        r_queued[r_edge_rd.head]  <= 1'b1;
                        r_pvalid[r_edge_rd.head]  <= 1'b1;
                    end
                    r_eidx  <= r_eidx + 1'b1;
                    r_state <= ST_EDGE_RD;
                end

                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_OUT;
                end

                ST_EMIT_OUT: begin
                    if (emit_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_node       <= r_idx[NODE_W-1:0];
                        r_o_dist       <= emit_reached ? r_dist_rd : '0;
                        r_o_reached    <= emit_reached;
                        r_o_parent     <= emit_parent ? r_par_rd : '0;
                        r_o_has_parent <= emit_parent;
                        r_o_dropped    <= r_overflow;
                        r_o_last       <= (r_idx + 1'b1 == node_lim);
                        if (r_idx + 1'b1 == node_lim) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `SSSP_ASSERT_HOLDS(a_etotal_bound, i_clk, i_rst_n, r_etotal <= ECNT_W'(MAX_EDGES), "edge count beyond table depth")
    `SSSP_ASSERT_HOLDS(a_queued_reached, i_clk, i_rst_n, (r_queued & ~r_reached) == '0, "queued node not reached")
    `SSSP_ASSERT_HOLDS(a_parent_reached, i_clk, i_rst_n, (r_pvalid & ~r_reached) == '0, "parent set on unreached node")
    `SSSP_ASSERT_NEXT(a_upd_to_rd, i_clk, i_rst_n, r_state == ST_EDGE_UPD, r_state == ST_EDGE_RD, "relax update not followed by next edge")
    `SSSP_ASSERT_NEXT(a_beat_kept, i_clk, i_rst_n, r_o_valid && !o_res.ready, r_o_valid, "pending result beat lost")

endmodule

`default_nettype wire

### dv/tb_single_source_shortest_paths_top.sv
// Self-checking bench for the shortest-path engine: edge loads, runs, clears and node reports.
`timescale 1ns / 1ps

module tb_single_source_shortest_paths_top;
    import sssp_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int EDGE_CAP      = 256;
    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 800;
    localparam int QUIET_LIMIT   = 300000;
    localparam int REPORT_MAX    = 10;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic [DIST_W-1:0] distance;
        logic              reached;
        logic [NODE_W-1:0] parent_index;
        logic              has_parent;
        logic              edges_dropped;
        logic              last;
    } t_node_report;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} t_chk;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        logic [REQ_W-1:0]      req;
        logic [NODE_W-1:0]     tail;
        logic [NODE_W-1:0]     head;
        logic [WEIGHT_W-1:0]   len;
        t_chk                  chk;
        t_node_report          report;
    } t_row;

    localparam t_node_report NO_REPORT = '0;
    localparam t_node_report SOURCE_ONLY = '{node_index: '0, distance: '0, reached: 1'b1,
        parent_index: '0, has_parent: 1'b0, edges_dropped: 1'b0, last: 1'b1};
    localparam t_node_report UNREACHED_ONLY = '{last: 1'b1, default: '0};

    localparam int DIRECTED_ROWS = 27;
    // kind, cfg index, cfg value, request, tail, head, length, check, typed report
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_CFG, CFG_NODE_COUNT,  7'd1,   REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        // single node graph right after reset: only the source
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_TYPED, SOURCE_ONLY},
        '{ROW_CFG, CFG_SOURCE_NODE, 7'd5,   REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        // source outside the node range
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_TYPED, UNREACHED_ONLY},
        '{ROW_CFG, CFG_NODE_COUNT,  7'd0,   REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        // zero nodes: no report at all
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_NONE, NO_REPORT},
        // count above the node limit folds to the limit
        '{ROW_CFG, CFG_NODE_COUNT,  7'd127, REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_CFG, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd0,  6'd1,  32'd0,
          CHK_PREDICT, NO_REPORT},
        // nodes 1 and 5 tie at distance 0, lower index settles first
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd0,  6'd5,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd1,  6'd2,  32'hFFFF_FFFF,
          CHK_PREDICT, NO_REPORT},
        // equal length path must not replace the parent
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd0,  6'd2,  32'hFFFF_FFFF,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd63, 6'd0,  32'd5,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd2,  6'd63, 32'd1,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd3,  6'd3,  32'd7,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd5,  6'd4,  32'd2,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd1,  6'd4,  32'd2,
          CHK_PREDICT, NO_REPORT},
        // unknown request is ignored
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF,
          CHK_NONE, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        // edges into node 63 and out of it are skipped now
        '{ROW_CFG, CFG_NODE_COUNT,  7'd3,   REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_CLEAR,  6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_CFG, CFG_SOURCE_NODE, 7'd63,  REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_CFG, CFG_NODE_COUNT,  7'd64,  REQ_ADD,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_ADD,    6'd63, 6'd10, 32'h8000_0000,
          CHK_PREDICT, NO_REPORT},
        '{ROW_REQ, CFG_SOURCE_NODE, 7'd0,   REQ_RUN,    6'd0,  6'd0,  32'd0,
          CHK_PREDICT, NO_REPORT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    sssp_req_if req_if ();
    sssp_res_if res_if ();

    single_source_shortest_paths_top #(
        .MAX_EDGES(EDGE_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the engine state
    logic [NODE_W-1:0]   edge_tail_sh [EDGE_CAP];
    logic [NODE_W-1:0]   edge_head_sh [EDGE_CAP];
    logic [WEIGHT_W-1:0] edge_len_sh  [EDGE_CAP];
    int unsigned         edge_cnt;
    logic                dropped_sh;
    logic [NODE_W-1:0]   cur_source;
    logic [CNT_W-1:0]    cur_count;

    t_node_report node_reports [$];

    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned fail_count;
    int unsigned report_count;
    int unsigned quiet_cycles;

    // Dijkstra over the shadow table; queues one report per node in use
    function automatic void solve_paths();
        int n;
        int best;
        int h;
        bit found;
        logic [DIST_W-1:0] key;
        logic [DIST_W-1:0] cand;
        logic [DIST_W:0]   sum;
        logic [DIST_W-1:0] node_dist [NODES];
        bit                reached   [NODES];
        bit                queued    [NODES];
        bit                has_par   [NODES];
        logic [NODE_W-1:0] par       [NODES];
        t_node_report      rep;
        n = (cur_count > NODE_LIMIT) ? NODES : int'(cur_count);
        for (int i = 0; i < NODES; i++) begin
            node_dist[i] = '0;
            reached[i] = 1'b0;
            queued[i] = 1'b0;
            has_par[i] = 1'b0;
            par[i] = '0;
        end
        if (int'(cur_source) < n) begin
            reached[cur_source] = 1'b1;
            queued[cur_source] = 1'b1;
            for (int round = 0; round < n; round++) begin
                found = 1'b0;
                best = 0;
                for (int i = 0; i < n; i++) begin
                    if (queued[i] && (!found || node_dist[i] < node_dist[best])) begin
                        best = i;
                        found = 1'b1;
                    end
                end
                if (!found) break;
                queued[best] = 1'b0;
                key = node_dist[best];
                for (int e = 0; e < int'(edge_cnt); e++) begin
                    h = int'(edge_head_sh[e]);
                    if (int'(edge_tail_sh[e]) == best && h < n) begin
                        sum = {1'b0, key} + (DIST_W + 1)'(edge_len_sh[e]);
                        cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
                        if (!reached[h] || cand < node_dist[h]) begin
                            node_dist[h] = cand;
                            par[h] = NODE_W'(best);
                            has_par[h] = 1'b1;
                            reached[h] = 1'b1;
                            queued[h] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            rep.node_index    = NODE_W'(i);
            rep.distance      = reached[i] ? node_dist[i] : '0;
            rep.reached       = reached[i];
            rep.parent_index  = (reached[i] && has_par[i]) ? par[i] : '0;
            rep.has_parent    = reached[i] && has_par[i];
            rep.edges_dropped = dropped_sh;
            rep.last          = (i == n - 1);
            node_reports.push_back(rep);
        end
    endfunction

    function automatic void track_request(input logic [REQ_W-1:0] kind,
                                          input logic [NODE_W-1:0] tail,
                                          input logic [NODE_W-1:0] head,
                                          input logic [WEIGHT_W-1:0] len);
        case (kind)
            REQ_ADD: begin
                if (edge_cnt < EDGE_CAP) begin
                    edge_tail_sh[edge_cnt] = tail;
                    edge_head_sh[edge_cnt] = head;
                    edge_len_sh[edge_cnt]  = len;
                    edge_cnt++;
                end else begin
                    dropped_sh = 1'b1;
                end
            end
            REQ_CLEAR: begin
                edge_cnt = 0;
                dropped_sh = 1'b0;
            end
            REQ_RUN: begin
                solve_paths();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        int span;
        span = (cur_count == 0) ? 1 : ((cur_count > NODE_LIMIT) ? NODES : int'(cur_count));
        if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, NODES - 1));
        return NODE_W'($urandom_range(0, span - 1));
    endfunction

    // small weights give plenty of ties
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom();
            default: return WEIGHT_W'($urandom_range(0, 15));
        endcase
    endfunction

    // one beat on the request channel; returns at the accepting edge
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] tail,
                            input logic [NODE_W-1:0] head, input logic [WEIGHT_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.edge_from   <= tail;
        req_if.edge_to     <= head;
        req_if.edge_weight <= len;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // idle mix follows the random item count, so each phase gets its share
    task automatic send_tracked(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] tail,
                                input logic [NODE_W-1:0] head,
                                input logic [WEIGHT_W-1:0] len);
        if (items_sent < 140) begin
            send_idle_pct = 22;
            recv_idle_pct = 77;
        end else if (items_sent < 280) begin
            send_idle_pct = 77;
            recv_idle_pct = 22;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        send_req(kind, tail, head, len);
        track_request(kind, tail, head, len);
        if (kind != REQ_UNUSED) items_sent++;
    endtask

    // registers only change with the engine idle and every report drained
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        req_if.valid <= 1'b0;
        while (node_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SOURCE_NODE) cur_source = val[NODE_W-1:0];
        else cur_count = val;
    endtask

    task automatic pick_config();
        int span;
        logic [CFG_DATA_W-1:0] count;
        logic [NODE_W-1:0] src;
        case ($urandom_range(0, 19))
            0: count = '0;
            1: count = CFG_DATA_W'(NODES);
            2: count = CFG_DATA_W'($urandom_range(NODES + 1, 127));
            3: count = CFG_DATA_W'(1);
            default: count = CFG_DATA_W'($urandom_range(2, 12));
        endcase
        span = (count == 0 || count > NODE_LIMIT) ? NODES : int'(count);
        if ($urandom_range(0, 6) == 0) src = NODE_W'($urandom_range(0, NODES - 1));
        else src = NODE_W'($urandom_range(0, span - 1));
        write_cfg(CFG_NODE_COUNT, count);
        write_cfg(CFG_SOURCE_NODE, CFG_DATA_W'(src));
    endtask

    // result side: random backpressure, checking, and the no-progress watchdog
    initial begin : report_check
        t_node_report got;
        t_node_report want;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = '{res_if.node_index, res_if.distance, res_if.reached,
                        res_if.parent_index, res_if.has_parent, res_if.edges_dropped,
                        res_if.last};
                if (node_reports.size() == 0) begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                        $display("unexpected report beat for node %0d", got.node_index);
                    report_count++;
                end else begin
                    want = node_reports.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (report_count < REPORT_MAX) begin
                            $display("report mismatch exp: node=%0d dist=%0d reached=%0b parent=%0d has_parent=%0b dropped=%0b last=%0b",
                                     want.node_index, want.distance, want.reached,
                                     want.parent_index, want.has_parent,
                                     want.edges_dropped, want.last);
                            $display("                got: node=%0d dist=%0d reached=%0b parent=%0d has_parent=%0b dropped=%0b last=%0b",
                                     got.node_index, got.distance, got.reached,
                                     got.parent_index, got.has_parent,
                                     got.edges_dropped, got.last);
                        end
                        report_count++;
                    end
                end
                quiet_cycles = 0;
            end else if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row row;
        int n_edges;
        bit overflow_done;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_SOURCE_NODE;
        i_cfg_wdata        <= '0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_ADD;
        req_if.edge_from   <= '0;
        req_if.edge_to     <= '0;
        req_if.edge_weight <= '0;
        edge_cnt      = 0;
        dropped_sh    = 1'b0;
        cur_source    = '0;
        cur_count     = NODE_COUNT_RESET;
        items_sent    = 0;
        fail_count    = 0;
        report_count  = 0;
        quiet_cycles  = 0;
        overflow_done = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 77;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                write_cfg(row.cfg_idx, row.cfg_val);
            end else begin
                send_req(row.req, row.tail, row.head, row.len);
                case (row.chk)
                    CHK_TYPED: node_reports.push_back(row.report);
                    CHK_PREDICT: track_request(row.req, row.tail, row.head, row.len);
                    default: begin
                    end
                endcase
            end
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!overflow_done && items_sent >= 150) begin
                // fill the table past capacity, run wide, then run narrow
                overflow_done = 1'b1;
                write_cfg(CFG_NODE_COUNT, CFG_DATA_W'(NODES));
                write_cfg(CFG_SOURCE_NODE, CFG_DATA_W'($urandom_range(0, NODES - 1)));
                send_tracked(REQ_CLEAR, '0, '0, '0);
                n_edges = EDGE_CAP + $urandom_range(1, 6);
                for (int e = 0; e < n_edges; e++)
                    send_tracked(REQ_ADD, pick_node(), pick_node(), pick_weight());
                send_tracked(REQ_RUN, '0, '0, '0);
                write_cfg(CFG_NODE_COUNT, CFG_DATA_W'($urandom_range(2, 8)));
                send_tracked(REQ_RUN, '0, '0, '0);
            end else begin
                if ($urandom_range(0, 1) == 0) pick_config();
                if ($urandom_range(0, 9) < 7 || edge_cnt > 160)
                    send_tracked(REQ_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()),
                                 $urandom());
                n_edges = $urandom_range(2, 20);
                for (int e = 0; e < n_edges; e++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_tracked(REQ_UNUSED, NODE_W'($urandom()), NODE_W'($urandom()),
                                     $urandom());
                    send_tracked(REQ_ADD, pick_node(), pick_node(), pick_weight());
                end
                send_tracked(REQ_RUN, NODE_W'($urandom()), NODE_W'($urandom()), $urandom());
                if ($urandom_range(0, 4) == 0)
                    send_tracked(REQ_RUN, '0, '0, '0);
            end
        end

        req_if.valid <= 1'b0;
        while (node_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && node_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
